// ===== design/bole_pkg.sv =====
// Package for the bounded ordered list engine: sizes, request and status codes,
// channel payload structs, controller states and the controller/datapath command set.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

   // Sizes
   localparam int DEPTH     = 16;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int VAL_W     = 32;
   localparam int REQ_W     = 4;
   localparam int POS_W     = 8;
   localparam int ST_W      = 3;
   localparam int CNT_OUT_W = 5;
   localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INS_FRONT = 4'd0,
      REQ_INS_REAR  = 4'd1,
      REQ_INS_POS   = 4'd2,
      REQ_DEL_FRONT = 4'd3,
      REQ_DEL_REAR  = 4'd4,
      REQ_DEL_POS   = 4'd5,
      REQ_DEL_KEY   = 4'd6,
      REQ_REVERSE   = 4'd7,
      REQ_LIST      = 4'd8
   } req_code_type;

   // Result status codes
   typedef enum logic [ST_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADPOS = 3'd2,
      ST_NOKEY  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic signed [VAL_W-1:0] operand_value;
      logic [POS_W-1:0]        position;
   } request_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] result_value;
      logic [CNT_OUT_W-1:0]    entry_count;
      logic                    last;
   } response_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_MV,
      S_INS_PUT,
      S_DEL_CAP,
      S_DEL_MV,
      S_DEL_END,
      S_KEY_CMP,
      S_REV_RDI,
      S_REV_RDJ,
      S_REV_WRI,
      S_REV_WRJ,
      S_LIST,
      S_DONE
   } state_type;

   // Datapath operations, one per cycle
   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_INS_START,
      DP_INS_RD,
      DP_INS_MV,
      DP_INS_PUT,
      DP_DEL_START,
      DP_DEL_CAP,
      DP_DEL_MV,
      DP_DEL_END,
      DP_SCAN_START,
      DP_KEY_NEXT,
      DP_REV_START,
      DP_REV_RDI,
      DP_REV_RDJ,
      DP_REV_WRI,
      DP_REV_WRJ,
      DP_LIST_EMIT,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       st_load;
      status_type st;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] code;
      logic             count_zero;
      logic             count_one;
      logic             full;
      logic             ins_pos_bad;
      logic             del_pos_bad;
      logic             ptr_eq_end;
      logic             ptr_m1_eq_end;
      logic             ptr_p1_eq_cnt;
      logic             ptr_p2_eq_cnt;
      logic             rev_more;
      logic             key_match;
      logic             out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== design/bole_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bole_ctrl.sv =====
// Controller for the ordered list engine: sequences each request over the datapath.
// Depends on bole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bole_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire bole_pkg::dp_stat_type stat,
   output bole_pkg::ctrl_cmd_type     cmd
);

   bole_pkg::state_type  state_ff;
   bole_pkg::state_type  state_in;
   bole_pkg::state_type  dec_next;
   bole_pkg::dp_op_type  dec_op;
   bole_pkg::status_type dec_st;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bole_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode the latched request: early-out status or the first datapath step
   always_comb begin
      dec_next = bole_pkg::S_DONE;
      dec_op   = bole_pkg::DP_NOP;
      dec_st   = bole_pkg::ST_OK;
      case (stat.code)
         bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_REAR: begin
            if (stat.full) begin
               dec_st = bole_pkg::ST_FULL;
            end else begin
               dec_op   = bole_pkg::DP_INS_START;
               dec_next = bole_pkg::S_INS_RD;
            end
         end
         bole_pkg::REQ_INS_POS: begin
            if (stat.full) begin
               dec_st = bole_pkg::ST_FULL;
            end else if (stat.ins_pos_bad) begin
               dec_st = bole_pkg::ST_BADPOS;
            end else begin
               dec_op   = bole_pkg::DP_INS_START;
               dec_next = bole_pkg::S_INS_RD;
            end
         end
         bole_pkg::REQ_DEL_FRONT, bole_pkg::REQ_DEL_REAR: begin
            if (stat.count_zero) begin
               dec_st = bole_pkg::ST_EMPTY;
            end else begin
               dec_op   = bole_pkg::DP_DEL_START;
               dec_next = bole_pkg::S_DEL_CAP;
            end
         end
         bole_pkg::REQ_DEL_POS: begin
            if (stat.count_zero) begin
               dec_st = bole_pkg::ST_EMPTY;
            end else if (stat.del_pos_bad) begin
               dec_st = bole_pkg::ST_BADPOS;
            end else begin
               dec_op   = bole_pkg::DP_DEL_START;
               dec_next = bole_pkg::S_DEL_CAP;
            end
         end
         bole_pkg::REQ_DEL_KEY: begin
            if (stat.count_zero) begin
               dec_st = bole_pkg::ST_EMPTY;
            end else begin
               dec_op   = bole_pkg::DP_SCAN_START;
               dec_next = bole_pkg::S_KEY_CMP;
            end
         end
         bole_pkg::REQ_REVERSE: begin
            if (stat.count_zero) begin
               dec_st = bole_pkg::ST_EMPTY;
            end else if (!stat.count_one) begin
               dec_op   = bole_pkg::DP_REV_START;
               dec_next = bole_pkg::S_REV_RDI;
            end
         end
         bole_pkg::REQ_LIST: begin
            if (stat.count_zero) begin
               dec_st = bole_pkg::ST_EMPTY;
            end else begin
               dec_op   = bole_pkg::DP_SCAN_START;
               dec_next = bole_pkg::S_LIST;
            end
         end
         default: begin
            dec_st = bole_pkg::ST_OK;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bole_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bole_pkg::S_DECODE;
            end
         end
         bole_pkg::S_DECODE: begin
            state_in = dec_next;
         end
         bole_pkg::S_INS_RD: begin
            state_in = stat.ptr_eq_end ? bole_pkg::S_INS_PUT : bole_pkg::S_INS_MV;
         end
         bole_pkg::S_INS_MV: begin
            if (stat.ptr_m1_eq_end) begin
               state_in = bole_pkg::S_INS_PUT;
            end
         end
         bole_pkg::S_INS_PUT: begin
            state_in = bole_pkg::S_DONE;
         end
         bole_pkg::S_DEL_CAP: begin
            state_in = stat.ptr_p1_eq_cnt ? bole_pkg::S_DEL_END : bole_pkg::S_DEL_MV;
         end
         bole_pkg::S_DEL_MV: begin
            if (stat.ptr_p2_eq_cnt) begin
               state_in = bole_pkg::S_DEL_END;
            end
         end
         bole_pkg::S_DEL_END: begin
            state_in = bole_pkg::S_DONE;
         end
         bole_pkg::S_KEY_CMP: begin
            if (stat.key_match) begin
               state_in = bole_pkg::S_DEL_CAP;
            end else if (stat.ptr_p1_eq_cnt) begin
               state_in = bole_pkg::S_DONE;
            end
         end
         bole_pkg::S_REV_RDI: begin
            state_in = bole_pkg::S_REV_RDJ;
         end
         bole_pkg::S_REV_RDJ: begin
            state_in = bole_pkg::S_REV_WRI;
         end
         bole_pkg::S_REV_WRI: begin
            state_in = bole_pkg::S_REV_WRJ;
         end
         bole_pkg::S_REV_WRJ: begin
            state_in = stat.rev_more ? bole_pkg::S_REV_RDI : bole_pkg::S_DONE;
         end
         bole_pkg::S_LIST: begin
            if (stat.out_free && stat.ptr_p1_eq_cnt) begin
               state_in = bole_pkg::S_IDLE;
            end
         end
         bole_pkg::S_DONE: begin
            if (stat.out_free) begin
               state_in = bole_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bole_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd.op      = bole_pkg::DP_NOP;
      cmd.st_load = 1'b0;
      cmd.st      = bole_pkg::ST_OK;
      req_stall   = (state_ff != bole_pkg::S_IDLE);
      case (state_ff)
         bole_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op = bole_pkg::DP_LATCH;
            end
         end
         bole_pkg::S_DECODE: begin
            cmd.op      = dec_op;
            cmd.st_load = 1'b1;
            cmd.st      = dec_st;
         end
         bole_pkg::S_INS_RD: begin
            if (!stat.ptr_eq_end) begin
               cmd.op = bole_pkg::DP_INS_RD;
            end
         end
         bole_pkg::S_INS_MV: begin
            cmd.op = bole_pkg::DP_INS_MV;
         end
         bole_pkg::S_INS_PUT: begin
            cmd.op = bole_pkg::DP_INS_PUT;
         end
         bole_pkg::S_DEL_CAP: begin
            cmd.op = bole_pkg::DP_DEL_CAP;
         end
         bole_pkg::S_DEL_MV: begin
            cmd.op = bole_pkg::DP_DEL_MV;
         end
         bole_pkg::S_DEL_END: begin
            cmd.op = bole_pkg::DP_DEL_END;
         end
         bole_pkg::S_KEY_CMP: begin
            // hold read data on a match so the delete step sees it
            if (!stat.key_match) begin
               if (stat.ptr_p1_eq_cnt) begin
                  cmd.st_load = 1'b1;
                  cmd.st      = bole_pkg::ST_NOKEY;
               end else begin
                  cmd.op = bole_pkg::DP_KEY_NEXT;
               end
            end
         end
         bole_pkg::S_REV_RDI: begin
            cmd.op = bole_pkg::DP_REV_RDI;
         end
         bole_pkg::S_REV_RDJ: begin
            cmd.op = bole_pkg::DP_REV_RDJ;
         end
         bole_pkg::S_REV_WRI: begin
            cmd.op = bole_pkg::DP_REV_WRI;
         end
         bole_pkg::S_REV_WRJ: begin
            cmd.op = bole_pkg::DP_REV_WRJ;
         end
         bole_pkg::S_LIST: begin
            if (stat.out_free) begin
               cmd.op = bole_pkg::DP_LIST_EMIT;
            end
         end
         bole_pkg::S_DONE: begin
            if (stat.out_free) begin
               cmd.op = bole_pkg::DP_FINISH;
            end
         end
         default: begin
            cmd.op = bole_pkg::DP_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/bole_dpath.sv =====
// Datapath for the ordered list engine: entry store, count, pointers and the
// result register. Depends on bole_pkg and bole_ram.
`timescale 1ns / 1ps
`default_nettype none

module bole_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bole_pkg::request_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bole_pkg::response_type      rsp_data,
   input  wire bole_pkg::ctrl_cmd_type cmd,
   output bole_pkg::dp_stat_type       stat
);

   localparam int CNT_W = bole_pkg::CNT_W;
   localparam int IDX_W = bole_pkg::IDX_W;
   localparam int VAL_W = bole_pkg::VAL_W;
   localparam int CMP_W = bole_pkg::CMP_W;

   bole_pkg::request_type  req_ff, req_in;
   bole_pkg::response_type rsp_ff, rsp_in;
   bole_pkg::status_type   st_ff, st_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       end_ff, end_in;
   logic [VAL_W-1:0]       dval_ff, dval_in;
   logic [VAL_W-1:0]       hold_ff, hold_in;

   logic [CNT_W-1:0] ptr_p1, ptr_p2, ptr_m1, ptr_m2, end_m1, count_p1, count_m1;
   logic [CNT_W-1:0] pos_m1, ins_idx, del_idx;
   logic [CMP_W-1:0] cnt_ext, pos_ext;
   logic             emit;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [VAL_W-1:0] wr_data, ram_rdata;

   bole_ram #(
      .WIDTH (VAL_W),
      .DEPTH (bole_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      st_ff   <= st_in;
      ptr_ff  <= ptr_in;
      end_ff  <= end_in;
      dval_ff <= dval_in;
      hold_ff <= hold_in;
   end

   assign ptr_p1   = ptr_ff + CNT_W'(1);
   assign ptr_p2   = ptr_ff + CNT_W'(2);
   assign ptr_m1   = ptr_ff - CNT_W'(1);
   assign ptr_m2   = ptr_ff - CNT_W'(2);
   assign end_m1   = end_ff - CNT_W'(1);
   assign count_p1 = count_ff + CNT_W'(1);
   assign count_m1 = count_ff - CNT_W'(1);
   assign pos_m1   = CNT_W'(req_ff.position - bole_pkg::POS_W'(1));
   assign cnt_ext  = CMP_W'(count_ff);
   assign pos_ext  = CMP_W'(req_ff.position);

   always_comb begin
      case (req_ff.req_type)
         bole_pkg::REQ_INS_FRONT: ins_idx = '0;
         bole_pkg::REQ_INS_REAR:  ins_idx = count_ff;
         default:                 ins_idx = pos_m1;
      endcase
      case (req_ff.req_type)
         bole_pkg::REQ_DEL_FRONT: del_idx = '0;
         bole_pkg::REQ_DEL_REAR:  del_idx = count_m1;
         default:                 del_idx = pos_m1;
      endcase
   end

   always_comb begin
      stat.code          = req_ff.req_type;
      stat.count_zero    = (count_ff == '0);
      stat.count_one     = (count_ff == CNT_W'(1));
      stat.full          = (count_ff == CNT_W'(bole_pkg::DEPTH));
      stat.ins_pos_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
      stat.del_pos_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
      stat.ptr_eq_end    = (ptr_ff == end_ff);
      stat.ptr_m1_eq_end = (ptr_m1 == end_ff);
      stat.ptr_p1_eq_cnt = (ptr_p1 == count_ff);
      stat.ptr_p2_eq_cnt = (ptr_p2 == count_ff);
      stat.rev_more      = (ptr_p1 < end_m1);
      stat.key_match     = (ram_rdata == $unsigned(req_ff.operand_value));
      stat.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      st_in    = st_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      end_in   = end_ff;
      dval_in  = dval_ff;
      hold_in  = hold_ff;
      emit     = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = ptr_ff[IDX_W-1:0];
      wr_data  = ram_rdata;

      if (cmd.st_load) begin
         st_in = cmd.st;
      end

      case (cmd.op)
         bole_pkg::DP_LATCH: begin
            req_in  = req_data;
            dval_in = '0;
         end
         bole_pkg::DP_INS_START: begin
            ptr_in = count_ff;
            end_in = ins_idx;
         end
         bole_pkg::DP_INS_RD: begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[IDX_W-1:0];
         end
         bole_pkg::DP_INS_MV: begin
            // move one entry toward the rear, fetch the next one down
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = ptr_m2[IDX_W-1:0];
            ptr_in  = ptr_m1;
         end
         bole_pkg::DP_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = end_ff[IDX_W-1:0];
            wr_data  = $unsigned(req_ff.operand_value);
            count_in = count_p1;
         end
         bole_pkg::DP_DEL_START: begin
            rd_en   = 1'b1;
            rd_addr = del_idx[IDX_W-1:0];
            ptr_in  = del_idx;
         end
         bole_pkg::DP_DEL_CAP: begin
            dval_in = ram_rdata;
            rd_en   = 1'b1;
            rd_addr = ptr_p1[IDX_W-1:0];
         end
         bole_pkg::DP_DEL_MV: begin
            // move one entry toward the front, fetch the next one up
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = ptr_p2[IDX_W-1:0];
            ptr_in  = ptr_p1;
         end
         bole_pkg::DP_DEL_END: begin
            count_in = count_m1;
         end
         bole_pkg::DP_SCAN_START: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            ptr_in  = '0;
         end
         bole_pkg::DP_KEY_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_p1[IDX_W-1:0];
            ptr_in  = ptr_p1;
         end
         bole_pkg::DP_REV_START: begin
            ptr_in = '0;
            end_in = count_m1;
         end
         bole_pkg::DP_REV_RDI: begin
            rd_en = 1'b1;
         end
         bole_pkg::DP_REV_RDJ: begin
            hold_in = ram_rdata;
            rd_en   = 1'b1;
            rd_addr = end_ff[IDX_W-1:0];
         end
         bole_pkg::DP_REV_WRI: begin
            wr_en = 1'b1;
         end
         bole_pkg::DP_REV_WRJ: begin
            wr_en   = 1'b1;
            wr_addr = end_ff[IDX_W-1:0];
            wr_data = hold_ff;
            ptr_in  = ptr_p1;
            end_in  = end_m1;
         end
         bole_pkg::DP_LIST_EMIT: begin
            emit                = 1'b1;
            rsp_in.status       = bole_pkg::ST_OK;
            rsp_in.result_value = $signed(ram_rdata);
            rsp_in.entry_count  = bole_pkg::CNT_OUT_W'(count_ff);
            rsp_in.last         = (ptr_p1 == count_ff);
            rd_en               = 1'b1;
            rd_addr             = ptr_p1[IDX_W-1:0];
            ptr_in              = ptr_p1;
         end
         bole_pkg::DP_FINISH: begin
            emit                = 1'b1;
            rsp_in.status       = st_ff;
            rsp_in.result_value = $signed(dval_ff);
            rsp_in.entry_count  = bole_pkg::CNT_OUT_W'(count_ff);
            rsp_in.last         = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result never overwrites one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_valid_ff) |-> !rsp_stall)
      else $error("result register overwritten while stalled");

   // Inserts only complete on a list with room, deletes only on a non-empty one
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bole_pkg::DP_INS_PUT) |-> (count_ff < CNT_W'(bole_pkg::DEPTH)))
      else $error("insert on a full list");

   a_del_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bole_pkg::DP_DEL_END) |-> (count_ff != '0))
      else $error("delete on an empty list");

   // The count moves only on the insert and delete completion steps
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(reset) || $past(cmd.op == bole_pkg::DP_INS_PUT)
                              || $past(cmd.op == bole_pkg::DP_DEL_END)))
      else $error("entry count changed outside an insert or delete");

   // Store write addresses stay below the store depth
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) < CNT_W'(bole_pkg::DEPTH)))
      else $error("store write out of range");

endmodule

`default_nettype wire

// ===== design/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: controller plus datapath.
// Depends on bole_pkg, bole_ctrl, bole_dpath (and bole_ram below it).
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_stall   bole_pkg::request_type  (one request)
//   rsp_     out        rsp_valid / rsp_stall   bole_pkg::response_type (one result)
//
// One request at a time. After acceptance, with the result register free: an early-out
// status goes from decode to the result; insert shifts one entry toward the rear per step,
// then puts the new one; delete captures the entry, then shifts one per step to the front;
// delete by key adds a compare step per entry scanned; reverse reads and writes each pair;
// a listing emits one result per entry. The single read and single write port of the entry
// store limits the shifts to one entry moved per cycle.
// Reset (synchronous) empties the list; the store itself is not cleared.
// A stalled result holds in the output register while the next request is accepted;
// a listing advances only as results are taken.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bole_pkg::request_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bole_pkg::response_type      rsp_data
);

   // Command and status between the sequencer and the datapath
   bole_pkg::ctrl_cmd_type cmd;
   bole_pkg::dp_stat_type  stat;

   // Sequence each request: decode, shift, scan or swap, then hand a result out
   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the entries, the count and the result register
   bole_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire
